// ===== rtl/core/fqkr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fqkr_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned DEPTH_DEF       = 16;
  localparam int unsigned ID_BITS_DEF     = 16;
  localparam int unsigned HANDLE_BITS_DEF = 16;

  // Fixed port field widths.
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned FIELD_W = 16;
  localparam int unsigned STAT_W  = 2;

  // Operation codes.
  localparam logic [KIND_W-1:0] KIND_PUT    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_GET    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd3;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  // Microprogram counter width and step addresses.
  localparam int unsigned UPC_W = 4;
  localparam logic [UPC_W-1:0] UA_PUT0  = 4'd0;
  localparam logic [UPC_W-1:0] UA_PUT1  = 4'd1;
  localparam logic [UPC_W-1:0] UA_PUTF  = 4'd2;
  localparam logic [UPC_W-1:0] UA_GET0  = 4'd3;
  localparam logic [UPC_W-1:0] UA_GET1  = 4'd4;
  localparam logic [UPC_W-1:0] UA_REM0  = 4'd5;
  localparam logic [UPC_W-1:0] UA_REM1  = 4'd6;
  localparam logic [UPC_W-1:0] UA_REM2  = 4'd7;
  localparam logic [UPC_W-1:0] UA_LK0   = 4'd8;
  localparam logic [UPC_W-1:0] UA_LK1   = 4'd9;
  localparam logic [UPC_W-1:0] UA_LK2   = 4'd10;
  localparam logic [UPC_W-1:0] UA_SH0   = 4'd11;
  localparam logic [UPC_W-1:0] UA_SH1   = 4'd12;
  localparam logic [UPC_W-1:0] UA_SH2   = 4'd13;
  localparam logic [UPC_W-1:0] UA_MISS  = 4'd14;

  // Control word fields.
  typedef enum logic [1:0] {WR_NONE, WR_NEW, WR_SHIFT} wr_e;
  typedef enum logic {PTR_HOLD, PTR_INC} ptr_e;
  typedef enum logic [1:0] {CNT_HOLD, CNT_INC, CNT_DEC} cnt_e;
  typedef enum logic [2:0] {RES_NONE, RES_OK, RES_MISS, RES_FULL, RES_GET, RES_LOOK} res_e;
  typedef enum logic [2:0] {CND_NEVER, CND_ALWAYS, CND_FULL, CND_EMPTY, CND_END,
                            CND_NOMATCH} cond_e;

  typedef struct packed {
    wr_e              wr;
    ptr_e             ptr;
    cnt_e             cnt;
    res_e             res;
    cond_e            cond;
    logic [UPC_W-1:0] tgt;
    logic             last;
  } ucw_t;

  // Sequencer to datapath.
  typedef struct packed {
    logic accept;
    logic run;
    ucw_t uw;
  } ctl_t;

  // Datapath to sequencer.
  typedef struct packed {
    logic full;
    logic empty;
    logic at_end;
    logic match;
  } flags_t;

  // First step of each operation.
  function automatic logic [UPC_W-1:0] entry_of(input logic [KIND_W-1:0] kind);
    logic [UPC_W-1:0] a;
    case (kind)
      KIND_PUT:    a = UA_PUT0;
      KIND_GET:    a = UA_GET0;
      KIND_REMOVE: a = UA_REM0;
      KIND_LOOKUP: a = UA_LK0;
      default:     a = UA_MISS;
    endcase
    return a;
  endfunction

  // The microprogram. A word whose condition holds jumps to its target,
  // otherwise control falls through to the next step; a last word ends the item.
  function automatic ucw_t ucode_rom(input logic [UPC_W-1:0] addr);
    ucw_t w;
    w = '{wr: WR_NONE, ptr: PTR_HOLD, cnt: CNT_HOLD, res: RES_NONE,
          cond: CND_NEVER, tgt: '0, last: 1'b0};
    case (addr)
      // Put: append at the tail unless full.
      UA_PUT0: begin
        w.cond = CND_FULL;
        w.tgt  = UA_PUTF;
      end
      UA_PUT1: begin
        w.wr   = WR_NEW;
        w.cnt  = CNT_INC;
        w.res  = RES_OK;
        w.last = 1'b1;
      end
      UA_PUTF: begin
        w.res  = RES_FULL;
        w.last = 1'b1;
      end
      // Get: the head is read while the empty test runs.
      UA_GET0: begin
        w.cond = CND_EMPTY;
        w.tgt  = UA_MISS;
      end
      UA_GET1: begin
        w.res  = RES_GET;
        w.ptr  = PTR_INC;
        w.cond = CND_ALWAYS;
        w.tgt  = UA_SH0;
      end
      // Remove: search for the oldest match, then close the gap.
      UA_REM0: begin
        w.cond = CND_END;
        w.tgt  = UA_MISS;
      end
      UA_REM1: begin
        w.ptr  = PTR_INC;
        w.cond = CND_NOMATCH;
        w.tgt  = UA_REM0;
      end
      UA_REM2: begin
        w.res  = RES_OK;
        w.cond = CND_ALWAYS;
        w.tgt  = UA_SH0;
      end
      // Lookup: search for the oldest match and return its handle.
      UA_LK0: begin
        w.cond = CND_END;
        w.tgt  = UA_MISS;
      end
      UA_LK1: begin
        w.ptr  = PTR_INC;
        w.cond = CND_NOMATCH;
        w.tgt  = UA_LK0;
      end
      UA_LK2: begin
        w.res  = RES_LOOK;
        w.last = 1'b1;
      end
      // Gap closing: move each later entry down by one slot.
      UA_SH0: begin
        w.cond = CND_END;
        w.tgt  = UA_SH2;
      end
      UA_SH1: begin
        w.wr   = WR_SHIFT;
        w.ptr  = PTR_INC;
        w.cond = CND_ALWAYS;
        w.tgt  = UA_SH0;
      end
      UA_SH2: begin
        w.cnt  = CNT_DEC;
        w.last = 1'b1;
      end
      UA_MISS: begin
        w.res  = RES_MISS;
        w.last = 1'b1;
      end
      default: begin
        w.last = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/fifo_queue_with_keyed_removal_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Ordered queue of up to DEPTH (id, handle) entries with put, get, remove by
// id and lookup by id. A beat is taken when start is high and busy is low; its
// single result appears on status_o, out_id_o and out_handle_o with done_o high for
// exactly one cycle, and must be captured then, as it cannot be held off.
// Busy falls in the strobe cycle, so the next beat can be taken there. A small
// microprogram walks a store with one registered read port and one write port
// one entry at a time: put appends at the tail, get reads the head and closes
// the gap, lookup searches from the head, and remove searches and then closes
// the gap. Remove and lookup act on the oldest matching id.
module fifo_queue_with_keyed_removal_unit #(
  parameter int unsigned DEPTH       = fqkr_pkg::DEPTH_DEF,
  parameter int unsigned ID_BITS     = fqkr_pkg::ID_BITS_DEF,
  parameter int unsigned HANDLE_BITS = fqkr_pkg::HANDLE_BITS_DEF
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            start,
  output logic                           busy,
  input  wire  [fqkr_pkg::KIND_W-1:0]    kind_i,
  input  wire  [fqkr_pkg::FIELD_W-1:0]   item_id_i,
  input  wire  [fqkr_pkg::FIELD_W-1:0]   item_handle_i,
  output logic                           done_o,
  output logic [fqkr_pkg::STAT_W-1:0]    status_o,
  output logic [fqkr_pkg::FIELD_W-1:0]   out_id_o,
  output logic [fqkr_pkg::FIELD_W-1:0]   out_handle_o
);
  import fqkr_pkg::*;

  ctl_t   ctl;
  flags_t flags;

  // Microcode sequencer.
  fqkr_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .kind_i  (kind_i),
    .flags_i (flags),
    .busy    (busy),
    .done_o  (done_o),
    .ctl_o   (ctl)
  );

  // Store, pointers and result registers.
  fqkr_dp #(
    .DEPTH       (DEPTH),
    .ID_BITS     (ID_BITS),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .item_id_i     (item_id_i),
    .item_handle_i (item_handle_i),
    .flags_o       (flags),
    .status_o      (status_o),
    .out_id_o      (out_id_o),
    .out_handle_o  (out_handle_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/fqkr_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fqkr_seq (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            start,
  input  wire  [fqkr_pkg::KIND_W-1:0]    kind_i,
  input  wire  fqkr_pkg::flags_t         flags_i,
  output logic                           busy,
  output logic                           done_o,
  output fqkr_pkg::ctl_t                 ctl_o
);
  import fqkr_pkg::*;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [UPC_W-1:0] upc_q, upc_d;
  ucw_t             uw;
  logic             take;
  logic             accept;

  assign accept = start && !busy_q;
  assign uw     = ucode_rom(upc_q);

  // Branch condition of the current control word.
  always_comb begin
    case (uw.cond)
      CND_NEVER:   take = 1'b0;
      CND_ALWAYS:  take = 1'b1;
      CND_FULL:    take = flags_i.full;
      CND_EMPTY:   take = flags_i.empty;
      CND_END:     take = flags_i.at_end;
      CND_NOMATCH: take = !flags_i.match;
      default:     take = 1'b0;
    endcase
  end

  // Next step: dispatch on a new beat, otherwise jump, fall through or finish.
  always_comb begin
    busy_d = busy_q;
    upc_d  = upc_q;
    done_d = 1'b0;
    if (!busy_q) begin
      if (start) begin
        busy_d = 1'b1;
        upc_d  = entry_of(kind_i);
      end
    end else if (uw.last) begin
      busy_d = 1'b0;
      done_d = 1'b1;
    end else if (take) begin
      upc_d = uw.tgt;
    end else begin
      upc_d = upc_q + UPC_W'(1);
    end
  end

  // Step counter and the result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      upc_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      upc_q  <= upc_d;
    end
  end

  assign busy          = busy_q;
  assign done_o        = done_q;
  assign ctl_o.accept  = accept;
  assign ctl_o.run     = busy_q;
  assign ctl_o.uw      = uw;

  // The strobe only appears once the sequencer has let go of the item.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> !busy_q)
    else $error("result strobe while still busy");

  // An accepted beat always starts the program.
  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |=> busy_q)
    else $error("accepted beat did not start the sequencer");

endmodule

`default_nettype wire

// ===== rtl/core/fqkr_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fqkr_dp #(
  parameter int unsigned DEPTH       = fqkr_pkg::DEPTH_DEF,
  parameter int unsigned ID_BITS     = fqkr_pkg::ID_BITS_DEF,
  parameter int unsigned HANDLE_BITS = fqkr_pkg::HANDLE_BITS_DEF
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire  fqkr_pkg::ctl_t            ctl_i,
  input  wire  [fqkr_pkg::FIELD_W-1:0]    item_id_i,
  input  wire  [fqkr_pkg::FIELD_W-1:0]    item_handle_i,
  output fqkr_pkg::flags_t                flags_o,
  output logic [fqkr_pkg::STAT_W-1:0]     status_o,
  output logic [fqkr_pkg::FIELD_W-1:0]    out_id_o,
  output logic [fqkr_pkg::FIELD_W-1:0]    out_handle_o
);
  import fqkr_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  // Entry store, slot 0 is the head.
  logic [ID_BITS-1:0]     id_mem  [DEPTH];
  logic [HANDLE_BITS-1:0] hnd_mem [DEPTH];

  logic [CW-1:0]          count_q, count_d;
  logic [CW-1:0]          ptr_q, ptr_d;
  logic [CW-1:0]          ptr_dec;
  logic [ID_BITS-1:0]     key_q;
  logic [HANDLE_BITS-1:0] hnd_q;
  logic [ID_BITS-1:0]     rd_id_q;
  logic [HANDLE_BITS-1:0] rd_hnd_q;
  logic [STAT_W-1:0]      res_st_q;
  logic [FIELD_W-1:0]     res_id_q;
  logic [FIELD_W-1:0]     res_hnd_q;
  ucw_t                   uw;
  logic                   run;

  assign uw      = ctl_i.uw;
  assign run     = ctl_i.run;
  assign ptr_dec = ptr_q - CW'(1);

  // Status flags for the branch logic.
  assign flags_o.full   = (count_q == CW'(DEPTH));
  assign flags_o.empty  = (count_q == '0);
  assign flags_o.at_end = (ptr_q == count_q);
  assign flags_o.match  = (rd_id_q == key_q);

  // Walk pointer and fill count.
  always_comb begin
    ptr_d   = ptr_q;
    count_d = count_q;
    if (ctl_i.accept) begin
      ptr_d = '0;
    end else if (run) begin
      if (uw.ptr == PTR_INC) begin
        ptr_d = ptr_q + CW'(1);
      end
      case (uw.cnt)
        CNT_HOLD: count_d = count_q;
        CNT_INC:  count_d = count_q + CW'(1);
        CNT_DEC:  count_d = count_q - CW'(1);
        default:  count_d = count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q   <= '0;
      count_q <= '0;
    end else begin
      ptr_q   <= ptr_d;
      count_q <= count_d;
    end
  end

  // Operands of the accepted beat.
  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      key_q <= ID_BITS'(item_id_i);
      hnd_q <= HANDLE_BITS'(item_handle_i);
    end
  end

  // Store: one registered read at the pointer, one write per cycle.
  always_ff @(posedge clk_i) begin
    rd_id_q  <= id_mem[ptr_q[AW-1:0]];
    rd_hnd_q <= hnd_mem[ptr_q[AW-1:0]];
    if (run && uw.wr == WR_NEW) begin
      id_mem[count_q[AW-1:0]]  <= key_q;
      hnd_mem[count_q[AW-1:0]] <= hnd_q;
    end else if (run && uw.wr == WR_SHIFT) begin
      id_mem[ptr_dec[AW-1:0]]  <= rd_id_q;
      hnd_mem[ptr_dec[AW-1:0]] <= rd_hnd_q;
    end
  end

  // Result registers, held until the next item's program sets them.
  always_ff @(posedge clk_i) begin
    if (run) begin
      case (uw.res)
        RES_OK: begin
          res_st_q  <= ST_OK;
          res_id_q  <= '0;
          res_hnd_q <= '0;
        end
        RES_MISS: begin
          res_st_q  <= ST_MISS;
          res_id_q  <= '0;
          res_hnd_q <= '0;
        end
        RES_FULL: begin
          res_st_q  <= ST_FULL;
          res_id_q  <= '0;
          res_hnd_q <= '0;
        end
        RES_GET: begin
          res_st_q  <= ST_OK;
          res_id_q  <= FIELD_W'(rd_id_q);
          res_hnd_q <= FIELD_W'(rd_hnd_q);
        end
        RES_LOOK: begin
          res_st_q  <= ST_OK;
          res_id_q  <= '0;
          res_hnd_q <= FIELD_W'(rd_hnd_q);
        end
        default: begin
          res_st_q  <= res_st_q;
        end
      endcase
    end
  end

  assign status_o     = res_st_q;
  assign out_id_o     = res_id_q;
  assign out_handle_o = res_hnd_q;

  // The fill count never passes the store depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CW'(DEPTH))
    else $error("fill count beyond depth");

  // An append is only issued when there is room.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (run && uw.wr == WR_NEW) |-> !flags_o.full)
    else $error("append into a full store");

  // A gap-closing write always targets a slot below the pointer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (run && uw.wr == WR_SHIFT) |-> (ptr_q != '0 && ptr_q < count_q))
    else $error("gap-closing write out of range");

endmodule

`default_nettype wire
